// File: src/index_free_list_allocator_assert.svh
// ----------------------------------------------------------------------------
// Index free-list allocator assertion macros
// Shorthand for clocked implications checked on clk_i with rst_ni low as reset.
// ----------------------------------------------------------------------------
`ifndef INDEX_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define INDEX_FREE_LIST_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ifla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list allocator package
// Request and result types, operation and status codes, shared constants.
// ----------------------------------------------------------------------------
package ifla_pkg;

  localparam int unsigned POOL_DEPTH_DEF    = 1024;
  localparam int unsigned ENTRY_COUNT_RESET = 1024;
  localparam int unsigned CfgW              = 11;
  localparam int unsigned IndexW            = 10;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IndexW-1:0] free_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] granted_index;
  } rsp_t;

endpackage

// File: src/ifla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ifla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/index_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list allocator
// A free answers in the cycle after the request.
// An allocate from a non-empty pool goes through ST_ALLOC, bound by the link
// memory read of the head entry; an empty allocate answers in the cycle after.
// After reset or a write of entry_count the list is rebuilt, one entry per
// cycle, while busy is high. Results cannot stall.
// ----------------------------------------------------------------------------
module index_free_list_allocator #(
  parameter int unsigned POOL_DEPTH = ifla_pkg::POOL_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  ifla_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [ifla_pkg::CfgW-1:0] cfg_wdata_i,
  output logic                      result_valid_o,
  output ifla_pkg::rsp_t            rsp_o
);

  import ifla_pkg::*;

  localparam int unsigned AddrW = $clog2(POOL_DEPTH);
  localparam int unsigned LinkW = $clog2(POOL_DEPTH + 1);
  localparam logic [LinkW-1:0] LinkInvalid = LinkW'(POOL_DEPTH);
  localparam int unsigned ResetCount =
    (ENTRY_COUNT_RESET > POOL_DEPTH) ? POOL_DEPTH : ENTRY_COUNT_RESET;

  typedef enum logic [2:0] {
    ST_INIT  = 3'b001,
    ST_IDLE  = 3'b010,
    ST_ALLOC = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [LinkW-1:0]  count_q, count_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [LinkW-1:0]  mem_wdata;
  logic              mem_re;
  logic [LinkW-1:0]  mem_rdata;

  logic              accept;
  logic [31:0]       cfg_wide;
  logic [LinkW-1:0]  cfg_count;
  logic [31:0]       idx_wide;
  logic              in_range;
  logic              head_empty;
  logic [LinkW-1:0]  ptr_inc;
  logic              init_last;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign cfg_wide   = 32'(cfg_wdata_i);
  assign cfg_count  = (cfg_wide == 32'd0) ? LinkW'(1) :
                      (cfg_wide > 32'(POOL_DEPTH)) ? LinkInvalid : LinkW'(cfg_wide);
  assign idx_wide   = 32'(req_i.free_index);
  assign in_range   = idx_wide < 32'(count_q);
  assign head_empty = head_q >= LinkInvalid;
  assign ptr_inc    = LinkW'(ptr_q) + LinkW'(1);
  assign init_last  = ptr_inc == count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    ptr_d     = ptr_q;
    valid_d   = 1'b0;
    rsp_d     = '{status: STATUS_OK, granted_index: '0};
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = LinkInvalid;
    mem_re    = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = init_last ? LinkInvalid : ptr_inc;
        ptr_d     = ptr_q + AddrW'(1);
        if (init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.cmd == CMD_ALLOC) begin
            if (head_empty) begin
              valid_d      = 1'b1;
              rsp_d.status = STATUS_EMPTY;
            end else begin
              mem_re  = 1'b1;
              state_d = ST_ALLOC;
            end
          end else begin
            valid_d = 1'b1;
            if (in_range) begin
              mem_we    = 1'b1;
              mem_waddr = idx_wide[AddrW-1:0];
              mem_wdata = head_q;
              head_d    = LinkW'(idx_wide);
            end else begin
              rsp_d.status = STATUS_RANGE;
            end
          end
        end
      end
      ST_ALLOC: begin
        head_d              = mem_rdata;
        mem_we              = 1'b1;
        mem_waddr           = head_q[AddrW-1:0];
        mem_wdata           = LinkInvalid;
        valid_d             = 1'b1;
        rsp_d.granted_index = IndexW'(head_q);
        state_d             = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      count_d = cfg_count;
      head_d  = '0;
      ptr_d   = '0;
      state_d = ST_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      count_q <= LinkW'(ResetCount);
      head_q  <= '0;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  ifla_ram #(
    .Width (LinkW),
    .Depth (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

// File: src/ifla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list allocator checker
// Port-level checks on request and result timing and on failed results, bound to the top level.
// ----------------------------------------------------------------------------
`include "index_free_list_allocator_assert.svh"

module ifla_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input ifla_pkg::req_t            req_i,
  input logic                      cfg_we_i,
  input logic [ifla_pkg::CfgW-1:0] cfg_wdata_i,
  input logic                      result_valid_o,
  input ifla_pkg::rsp_t            rsp_o
);

  import ifla_pkg::*;

  logic accepted;
  logic cfg_seen;

  assign accepted = start && !busy;
  assign cfg_seen = cfg_we_i && (cfg_wdata_i == cfg_wdata_i);

  `IFLA_ASSERT_NEXT(a_free_answers, accepted && (req_i.cmd == CMD_FREE), result_valid_o, "free request did not answer in the next cycle")
  `IFLA_ASSERT_NEXT(a_alloc_timing, accepted && (req_i.cmd == CMD_ALLOC), !result_valid_o || (rsp_o.status == STATUS_EMPTY), "allocate answered early with a non-empty status")
  `IFLA_ASSERT_SAME(a_fail_zero_index, result_valid_o && (rsp_o.status != STATUS_OK), rsp_o.granted_index == '0, "failed request returned a non-zero index")
  `IFLA_ASSERT_NEXT(a_cfg_rebuilds, cfg_seen, busy, "configuration write did not start a list rebuild")

endmodule

bind index_free_list_allocator ifla_checker u_ifla_checker (.*);
